[rtl/adp_pkg.sv]
package adp_pkg;

	localparam logic [3:0] PC_REG    = 4'd15;
	localparam logic [7:0] IMM_MASK  = 8'hFF;

	typedef enum logic [3:0] {
		OP_AND = 4'd0,
		OP_EOR = 4'd1,
		OP_SUB = 4'd2,
		OP_RSB = 4'd3,
		OP_ADD = 4'd4,
		OP_ADC = 4'd5,
		OP_SBC = 4'd6,
		OP_RSC = 4'd7,
		OP_TST = 4'd8,
		OP_TEQ = 4'd9,
		OP_CMP = 4'd10,
		OP_CMN = 4'd11,
		OP_ORR = 4'd12,
		OP_MOV = 4'd13,
		OP_BIC = 4'd14,
		OP_MVN = 4'd15
	} alu_op_t;

	typedef enum logic [1:0] {
		SH_LSL = 2'd0,
		SH_LSR = 2'd1,
		SH_ASR = 2'd2,
		SH_ROR = 2'd3
	} shift_t;

	typedef struct packed {
		logic [31:0] instruction;
		logic [31:0] first_value;
		logic [31:0] second_value;
		logic [7:0]  shift_reg_value;
		logic [3:0]  flags_in;
	} req_item_t;

	typedef struct packed {
		logic [31:0] result;
		logic        write_result;
		logic [3:0]  flags_out;
		logic        restore_status;
		logic        dest_is_pc;
		logic        extra_cycle;
	} rsp_item_t;

	// operands and control entering the ALU stage
	typedef struct packed {
		alu_op_t     opcode;
		logic        s;
		logic [3:0]  rd;
		logic [31:0] op1;
		logic [31:0] b;
		logic        sc;
		logic [3:0]  flags;
		logic        regshift;
	} alu_in_t;

endpackage

[rtl/adp_req_if.sv]
interface adp_req_if;
	import adp_pkg::*;

	logic      valid;
	logic      ready;
	req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/adp_rsp_if.sv]
interface adp_rsp_if;
	import adp_pkg::*;

	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/arm_data_processing_alu.sv]
// ARMv4 data-processing ALU with barrel shifter. One instruction beat enters
// per cycle on req while rsp is not stalled, and its result beat leaves on rsp
// after three register stages: decode and
// operand fixup (r15 plus 4 on register-specified shifts, immediate turned
// into a rotate), barrel shifter, then adder/logic unit with flag update.
// Each stage holds its beat while the stage after it is full and stalled, so
// a stalled rsp fills the pipe before req.ready drops. The caller handles
// mode switch on restore_status, flushing on dest_is_pc and PC alignment.
module arm_data_processing_alu (
	input  logic      clk,
	input  logic      arst_n,
	adp_req_if.sink   req,
	adp_rsp_if.source rsp
);
	import adp_pkg::*;

	typedef struct packed {
		alu_op_t     opcode;
		logic        s;
		logic [3:0]  rd;
		logic [31:0] op1;
		shift_t      sh_type;
		logic [31:0] sh_value;
		logic [7:0]  sh_amount;
		logic        by_imm;
		logic [3:0]  flags;
		logic        regshift;
	} dec_t;

	logic      v_s1, v_s2, v_s3;
	logic      adv1, adv2, adv3;
	dec_t      dec;
	dec_t      dec_s1;
	alu_in_t   alu_in;
	alu_in_t   alu_s2;
	rsp_item_t item;
	rsp_item_t item_s3;
	logic [31:0] sh_result;
	logic        sh_carry;

	logic [31:0] ins;
	logic        regshift;
	logic [31:0] op2;

	assign adv3      = !v_s3 || rsp.ready;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign req.ready = adv1;

	always_comb begin
		ins      = req.data.instruction;
		regshift = !ins[25] && ins[4];
		op2      = (regshift && ins[3:0] == PC_REG) ?
			req.data.second_value + 32'd4 : req.data.second_value;

		dec.opcode = alu_op_t'(ins[24:21]);
		dec.s      = ins[20];
		dec.rd     = ins[15:12];
		dec.op1    = (regshift && ins[19:16] == PC_REG) ?
			req.data.first_value + 32'd4 : req.data.first_value;
		dec.flags    = req.data.flags_in;
		dec.regshift = regshift;
		if (ins[25]) begin
			// immediate: rotate right by twice the count, carry rule matches ROR
			dec.sh_type   = SH_ROR;
			dec.sh_value  = {24'd0, ins[7:0] & IMM_MASK};
			dec.sh_amount = {3'd0, ins[11:8], 1'b0};
			dec.by_imm    = 1'b0;
		end else if (regshift) begin
			dec.sh_type   = shift_t'(ins[6:5]);
			dec.sh_value  = op2;
			dec.sh_amount = req.data.shift_reg_value;
			dec.by_imm    = 1'b0;
		end else begin
			dec.sh_type   = shift_t'(ins[6:5]);
			dec.sh_value  = op2;
			dec.sh_amount = {3'd0, ins[11:7]};
			dec.by_imm    = 1'b1;
		end
	end

	adp_shifter u_shifter (
		.sh_type   (dec_s1.sh_type),
		.value     (dec_s1.sh_value),
		.amount    (dec_s1.sh_amount),
		.by_imm    (dec_s1.by_imm),
		.carry_in  (dec_s1.flags[1]),
		.result    (sh_result),
		.carry_out (sh_carry)
	);

	always_comb begin
		alu_in.opcode   = dec_s1.opcode;
		alu_in.s        = dec_s1.s;
		alu_in.rd       = dec_s1.rd;
		alu_in.op1      = dec_s1.op1;
		alu_in.b        = sh_result;
		alu_in.sc       = sh_carry;
		alu_in.flags    = dec_s1.flags;
		alu_in.regshift = dec_s1.regshift;
	end

	adp_alu u_alu (
		.alu_in (alu_s2),
		.item   (item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= req.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// payload advances only with a live beat; hold otherwise
	always_ff @(posedge clk) begin
		if (adv1 && req.valid) dec_s1 <= dec;
		if (adv2 && v_s1) alu_s2 <= alu_in;
		if (adv3 && v_s2) item_s3 <= item;
	end

	assign rsp.valid = v_s3;
	assign rsp.data  = item_s3;
endmodule

[rtl/adp_shifter.sv]
module adp_shifter (
	input  adp_pkg::shift_t sh_type,
	input  logic [31:0]     value,
	input  logic [7:0]      amount,
	input  logic            by_imm,
	input  logic            carry_in,
	output logic [31:0]     result,
	output logic            carry_out
);
	import adp_pkg::*;

	logic [32:0]        lsl_x;
	logic [32:0]        lsr_x;
	logic signed [32:0] asr_x;
	logic [63:0]        ror_x;
	logic               zero;
	logic               ge32;
	logic               eq32;
	logic               sign;

	always_comb begin
		lsl_x = {1'b0, value} << amount[4:0];
		lsr_x = {value, 1'b0} >> amount[4:0];
		asr_x = $signed({value, 1'b0}) >>> amount[4:0];
		ror_x = {value, value} >> amount[4:0];
		zero  = (amount == 8'd0);
		ge32  = |amount[7:5];
		eq32  = (amount == 8'd32);
		sign  = value[31];

		result    = value;
		carry_out = carry_in;
		case (sh_type)
			SH_LSL: begin
				if (zero) begin
					result    = value;
					carry_out = carry_in;
				end else if (ge32) begin
					result    = '0;
					carry_out = eq32 & value[0];
				end else begin
					result    = lsl_x[31:0];
					carry_out = lsl_x[32];
				end
			end
			SH_LSR: begin
				// immediate amount of zero encodes a shift by 32
				if (zero && !by_imm) begin
					result    = value;
					carry_out = carry_in;
				end else if (ge32 || zero) begin
					result    = '0;
					carry_out = (eq32 || zero) & sign;
				end else begin
					result    = lsr_x[32:1];
					carry_out = lsr_x[0];
				end
			end
			SH_ASR: begin
				if (zero && !by_imm) begin
					result    = value;
					carry_out = carry_in;
				end else if (ge32 || zero) begin
					result    = {32{sign}};
					carry_out = sign;
				end else begin
					result    = asr_x[32:1];
					carry_out = asr_x[0];
				end
			end
			SH_ROR: begin
				if (zero) begin
					if (by_imm) begin
						// rotate right extended through carry
						result    = {carry_in, value[31:1]};
						carry_out = value[0];
					end else begin
						result    = value;
						carry_out = carry_in;
					end
				end else if (amount[4:0] == 5'd0) begin
					result    = value;
					carry_out = sign;
				end else begin
					result    = ror_x[31:0];
					carry_out = ror_x[31];
				end
			end
			default: begin
				result    = value;
				carry_out = carry_in;
			end
		endcase
	end
endmodule

[rtl/adp_alu.sv]
module adp_alu (
	input  adp_pkg::alu_in_t   alu_in,
	output adp_pkg::rsp_item_t item
);
	import adp_pkg::*;

	logic [31:0] x;
	logic [31:0] y;
	logic        ci;
	logic [32:0] sum;
	logic [31:0] r;
	logic        logical;
	logic        nc;
	logic        nv;
	logic        restore;
	logic        upd;
	logic        wr;
	logic        c_in;

	always_comb begin
		c_in = alu_in.flags[1];
		x    = alu_in.op1;
		y    = alu_in.b;
		ci   = 1'b0;
		case (alu_in.opcode)
			OP_SUB, OP_CMP: begin
				x  = alu_in.op1;
				y  = ~alu_in.b;
				ci = 1'b1;
			end
			OP_RSB: begin
				x  = alu_in.b;
				y  = ~alu_in.op1;
				ci = 1'b1;
			end
			OP_ADC: ci = c_in;
			OP_SBC: begin
				y  = ~alu_in.b;
				ci = c_in;
			end
			OP_RSC: begin
				x  = alu_in.b;
				y  = ~alu_in.op1;
				ci = c_in;
			end
			default: begin
				x  = alu_in.op1;
				y  = alu_in.b;
				ci = 1'b0;
			end
		endcase
		sum = {1'b0, x} + {1'b0, y} + {32'd0, ci};

		logical = 1'b1;
		case (alu_in.opcode)
			OP_AND, OP_TST: r = alu_in.op1 & alu_in.b;
			OP_EOR, OP_TEQ: r = alu_in.op1 ^ alu_in.b;
			OP_ORR:         r = alu_in.op1 | alu_in.b;
			OP_MOV:         r = alu_in.b;
			OP_BIC:         r = alu_in.op1 & ~alu_in.b;
			OP_MVN:         r = ~alu_in.b;
			default: begin
				r       = sum[31:0];
				logical = 1'b0;
			end
		endcase

		nc = logical ? alu_in.sc : sum[32];
		nv = logical ? alu_in.flags[0] : (~(x[31] ^ y[31]) & (x[31] ^ sum[31]));

		restore = (alu_in.rd == PC_REG) && alu_in.s;
		upd     = alu_in.s && !restore;
		wr      = !(alu_in.opcode inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});

		item.result         = wr ? r : '0;
		item.write_result   = wr;
		item.flags_out      = upd ? {r[31], (r == 32'd0), nc, nv} : alu_in.flags;
		item.restore_status = restore;
		item.dest_is_pc     = (alu_in.rd == PC_REG);
		item.extra_cycle    = alu_in.regshift;
	end
endmodule

[verif/arm_data_processing_alu_test.sv]
`timescale 1ns / 1ps

module arm_data_processing_alu_test;
	import adp_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_ITEMS = 1300;
	localparam int unsigned LONG_HOLD_CYCLES = 100;

	class alu_scoreboard;
		rsp_item_t expected_results[$];
		int unsigned failures;

		function logic [31:0] rotate_right(input logic [31:0] val, input int n);
			if (n == 0) begin
				return val;
			end
			return (val >> n) | (val << (32 - n));
		endfunction

		function void barrel_shift(input shift_t kind, input logic [31:0] val, input int amt,
			input bit by_imm, input logic cin, output logic [31:0] res, output logic cout);
			int k;
			logic sign;
			sign = val[31];
			if (amt == 0 && (!by_imm || kind == SH_LSL)) begin
				res = val;
				cout = cin;
			end else if (amt == 0 && kind == SH_ROR) begin
				// rotate right extended through carry
				res = {cin, val[31:1]};
				cout = val[0];
			end else begin
				k = (amt == 0) ? 32 : amt;
				case (kind)
					SH_LSL: begin
						if (k < 32) begin
							res = val << k;
							cout = val[32 - k];
						end else begin
							res = '0;
							cout = (k == 32) ? val[0] : 1'b0;
						end
					end
					SH_LSR: begin
						if (k < 32) begin
							res = val >> k;
							cout = val[k - 1];
						end else begin
							res = '0;
							cout = (k == 32) ? sign : 1'b0;
						end
					end
					SH_ASR: begin
						if (k < 32) begin
							res = $signed(val) >>> k;
							cout = val[k - 1];
						end else begin
							res = {32{sign}};
							cout = sign;
						end
					end
					default: begin
						if (k % 32 == 0) begin
							res = val;
							cout = sign;
						end else begin
							res = rotate_right(val, k % 32);
							cout = val[k % 32 - 1];
						end
					end
				endcase
			end
		endfunction

		function logic [31:0] add_with_carry(input logic [31:0] a, input logic [31:0] b,
			input logic cin, output logic co, output logic vo);
			logic [32:0] sum;
			sum = {1'b0, a} + {1'b0, b} + {32'b0, cin};
			co = sum[32];
			vo = (a[31] == b[31]) && (sum[31] != a[31]);
			return sum[31:0];
		endfunction

		function rsp_item_t execute_instruction(input req_item_t item);
			logic [31:0] ins, op1, op2, b, r;
			logic [3:0] rd, rn, rm, fl;
			logic s, imm, regshift, sc, nc, nv, logical, restore;
			alu_op_t opc;
			int rot;
			rsp_item_t res;
			ins = item.instruction;
			op1 = item.first_value;
			op2 = item.second_value;
			fl = item.flags_in;
			rd = ins[15:12];
			rn = ins[19:16];
			rm = ins[3:0];
			s = ins[20];
			opc = alu_op_t'(ins[24:21]);
			imm = ins[25];
			regshift = !imm && ins[4];
			sc = fl[1];
			if (imm) begin
				rot = int'({ins[11:8], 1'b0});
				b = rotate_right({24'b0, ins[7:0]}, rot);
				if (rot != 0) begin
					sc = b[31];
				end
			end else if (regshift) begin
				// r15 reads one word further ahead on a register-specified shift
				if (rn == PC_REG) begin
					op1 = op1 + 32'd4;
				end
				if (rm == PC_REG) begin
					op2 = op2 + 32'd4;
				end
				barrel_shift(shift_t'(ins[6:5]), op2, int'(item.shift_reg_value), 1'b0, fl[1],
					b, sc);
			end else begin
				barrel_shift(shift_t'(ins[6:5]), op2, int'(ins[11:7]), 1'b1, fl[1], b, sc);
			end
			nc = fl[1];
			nv = fl[0];
			logical = 1'b0;
			case (opc)
				OP_AND, OP_TST: begin
					r = op1 & b;
					logical = 1'b1;
				end
				OP_EOR, OP_TEQ: begin
					r = op1 ^ b;
					logical = 1'b1;
				end
				OP_SUB, OP_CMP: r = add_with_carry(op1, ~b, 1'b1, nc, nv);
				OP_RSB:         r = add_with_carry(b, ~op1, 1'b1, nc, nv);
				OP_ADD, OP_CMN: r = add_with_carry(op1, b, 1'b0, nc, nv);
				OP_ADC:         r = add_with_carry(op1, b, fl[1], nc, nv);
				OP_SBC:         r = add_with_carry(op1, ~b, fl[1], nc, nv);
				OP_RSC:         r = add_with_carry(b, ~op1, fl[1], nc, nv);
				OP_ORR: begin
					r = op1 | b;
					logical = 1'b1;
				end
				OP_MOV: begin
					r = b;
					logical = 1'b1;
				end
				OP_BIC: begin
					r = op1 & ~b;
					logical = 1'b1;
				end
				default: begin
					r = ~b;
					logical = 1'b1;
				end
			endcase
			if (logical) begin
				nc = sc;
				nv = fl[0];
			end
			restore = (rd == PC_REG) && s;
			res.flags_out = fl;
			if (s && !restore) begin
				res.flags_out = {r[31], r == 32'd0, nc, nv};
			end
			res.write_result = !(opc >= OP_TST && opc <= OP_CMN);
			res.result = res.write_result ? r : 32'd0;
			res.restore_status = restore;
			res.dest_is_pc = (rd == PC_REG);
			res.extra_cycle = regshift;
			return res;
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		function void report_failure(input string msg);
			failures++;
			if (failures <= 10) begin
				$display("[%0t] %s", $realtime, msg);
			end
		endfunction

		function void note_instruction(input req_item_t item);
			expected_results.push_back(execute_instruction(item));
		endfunction

		function void check_result(input rsp_item_t got);
			rsp_item_t exp;
			if (expected_results.size() == 0) begin
				report_failure($sformatf("result beat with nothing outstanding: %p", got));
				return;
			end
			exp = expected_results.pop_front();
			if (got.result !== exp.result || got.write_result !== exp.write_result
				|| got.flags_out !== exp.flags_out || got.restore_status !== exp.restore_status
				|| got.dest_is_pc !== exp.dest_is_pc || got.extra_cycle !== exp.extra_cycle) begin
				report_failure($sformatf(
					"result %h/%h write %b/%b flags %h/%h restore %b/%b pc %b/%b extra %b/%b (exp/act)",
					exp.result, got.result, exp.write_result, got.write_result,
					exp.flags_out, got.flags_out, exp.restore_status, got.restore_status,
					exp.dest_is_pc, got.dest_is_pc, exp.extra_cycle, got.extra_cycle));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	adp_req_if req_if();
	adp_rsp_if rsp_if();

	alu_scoreboard results_board;
	int unsigned quiet_cycles;
	bit burst_mode;
	bit hold_off_request;

	arm_data_processing_alu u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [31:0] dp_word(input logic imm, input alu_op_t op, input logic s,
		input logic [3:0] rn, input logic [3:0] rd, input logic [11:0] operand2);
		return {4'hE, 2'b00, imm, op, s, rn, rd, operand2};
	endfunction

	function automatic logic [11:0] imm_shift(input logic [4:0] amt, input shift_t kind,
		input logic [3:0] rm);
		return {amt, kind, 1'b0, rm};
	endfunction

	function automatic logic [11:0] reg_shift(input logic [3:0] rs, input shift_t kind,
		input logic [3:0] rm);
		return {rs, 1'b0, kind, 1'b1, rm};
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 3);
			5: return 32'hFFFF_FFFC + $urandom_range(0, 3);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [7:0] pick_shift_amount();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'($urandom_range(1, 31));
			2: return 8'd32;
			3: return 8'($urandom_range(33, 255));
			4: return 8'(32 * $urandom_range(1, 7));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic req_item_t random_instruction();
		req_item_t item;
		logic [11:0] operand2;
		logic [3:0] rn, rd, rm;
		logic imm;
		rn = ($urandom_range(0, 3) == 0) ? PC_REG : 4'($urandom());
		rd = ($urandom_range(0, 4) == 0) ? PC_REG : 4'($urandom());
		rm = ($urandom_range(0, 3) == 0) ? PC_REG : 4'($urandom());
		imm = ($urandom_range(0, 2) == 0);
		if (imm) begin
			operand2 = 12'($urandom());
		end else if ($urandom_range(0, 1) == 1) begin
			operand2 = {4'($urandom()), ($urandom_range(0, 9) == 0), 2'($urandom()), 1'b1, rm};
		end else begin
			operand2 = {($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom()), 2'($urandom()),
				1'b0, rm};
		end
		item.instruction = dp_word(imm, alu_op_t'($urandom_range(0, 15)),
			$urandom_range(0, 3) != 0, rn, rd, operand2);
		item.instruction[31:28] = 4'($urandom());
		// some raw words to exercise the bits a well-formed encoding keeps fixed
		if ($urandom_range(0, 9) < 3) begin
			item.instruction = $urandom();
		end
		item.first_value = pick_operand();
		item.second_value = pick_operand();
		item.shift_reg_value = pick_shift_amount();
		item.flags_in = 4'($urandom());
		return item;
	endfunction

	task automatic send_item(input req_item_t item);
		int gap;
		req_if.data <= item;
		req_if.valid <= 1'b1;
		@(posedge clk);
		while (!req_if.ready) begin
			@(posedge clk);
		end
		gap = burst_mode ? 0 : idle_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_fields(input logic [31:0] word, input logic [31:0] a,
		input logic [31:0] b, input logic [7:0] amt, input logic [3:0] fl);
		req_item_t item;
		item = '{word, a, b, amt, fl};
		send_item(item);
	endtask

	// drop valid and hold until every outstanding result is back
	task automatic settle();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (results_board.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic run_directed();
		send_fields(dp_word(1'b1, OP_AND, 1'b1, 4'd1, 4'd2, {4'd0, 8'hFF}), 32'hFFFF_FFFF,
			32'd0, 8'd0, 4'h0);
		send_fields(dp_word(1'b1, OP_EOR, 1'b1, 4'd1, 4'd2, {4'd4, 8'h80}), 32'h0000_0001,
			32'd0, 8'd0, 4'h0);
		send_fields(dp_word(1'b0, OP_SUB, 1'b1, 4'd1, 4'd2, imm_shift(5'd0, SH_LSL, 4'd3)),
			32'd0, 32'd1, 8'd0, 4'h0);
		send_fields(dp_word(1'b0, OP_RSB, 1'b1, 4'd1, 4'd2, imm_shift(5'd0, SH_LSR, 4'd3)),
			32'h7FFF_FFFF, 32'h8000_0000, 8'd0, 4'hF);
		send_fields(dp_word(1'b0, OP_ADD, 1'b1, 4'd1, 4'd2, imm_shift(5'd0, SH_ASR, 4'd3)),
			32'h7FFF_FFFF, 32'h8000_0000, 8'd0, 4'h0);
		send_fields(dp_word(1'b0, OP_ADC, 1'b1, 4'd1, 4'd2, imm_shift(5'd0, SH_ROR, 4'd3)),
			32'h7FFF_FFFF, 32'h0000_0001, 8'd0, 4'h2);
		send_fields(dp_word(1'b0, OP_SBC, 1'b1, 4'd1, 4'd2, reg_shift(4'd4, SH_LSL, 4'd3)),
			32'd5, 32'd5, 8'd0, 4'h0);
		send_fields(dp_word(1'b0, OP_RSC, 1'b1, 4'd1, 4'd2, reg_shift(4'd4, SH_LSL, 4'd3)),
			32'd1, 32'h0000_0003, 8'd32, 4'h2);
		send_fields(dp_word(1'b0, OP_TST, 1'b1, 4'd1, 4'd2, reg_shift(4'd4, SH_LSL, 4'd3)),
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd33, 4'h2);
		send_fields(dp_word(1'b0, OP_TEQ, 1'b1, 4'd1, 4'd2, reg_shift(4'd4, SH_LSR, 4'd3)),
			32'h0, 32'h8000_0000, 8'd32, 4'h0);
		send_fields(dp_word(1'b0, OP_CMP, 1'b1, 4'd1, 4'd2, reg_shift(4'd4, SH_LSR, 4'd3)),
			32'h8000_0000, 32'hFFFF_FFFF, 8'd200, 4'h2);
		send_fields(dp_word(1'b0, OP_CMN, 1'b1, 4'd1, 4'd2, reg_shift(4'd4, SH_ASR, 4'd3)),
			32'h0000_0001, 32'h8000_0000, 8'd40, 4'h0);
		send_fields(dp_word(1'b0, OP_ORR, 1'b1, 4'd1, 4'd2, reg_shift(4'd4, SH_ROR, 4'd3)),
			32'd0, 32'h8000_0001, 8'd32, 4'h0);
		send_fields(dp_word(1'b0, OP_MOV, 1'b1, 4'd1, 4'd2, reg_shift(4'd4, SH_ROR, 4'd3)),
			32'd0, 32'h0000_0000, 8'd64, 4'hF);
		send_fields(dp_word(1'b0, OP_BIC, 1'b1, 4'd1, 4'd2, reg_shift(4'd4, SH_ROR, 4'd3)),
			32'hFFFF_FFFF, 32'h0000_0001, 8'd255, 4'h0);
		send_fields(dp_word(1'b0, OP_MVN, 1'b1, 4'd1, 4'd2, imm_shift(5'd31, SH_LSL, 4'd3)),
			32'd0, 32'h0000_0001, 8'd0, 4'h0);
		send_fields(dp_word(1'b0, OP_ADD, 1'b1, PC_REG, 4'd2, reg_shift(4'd4, SH_LSL, PC_REG)),
			32'hFFFF_FFFC, 32'hFFFF_FFFE, 8'd0, 4'h0);
		send_fields(dp_word(1'b0, OP_ADC, 1'b1, 4'd1, PC_REG, imm_shift(5'd1, SH_LSR, 4'd3)),
			32'hFFFF_FFFF, 32'h0000_0002, 8'd0, 4'hA);
		send_fields(dp_word(1'b1, OP_MOV, 1'b0, 4'd1, PC_REG, {4'd1, 8'h03}), 32'd0, 32'd0,
			8'd0, 4'h5);
		send_fields(dp_word(1'b0, OP_CMP, 1'b0, 4'd1, 4'd2, imm_shift(5'd0, SH_LSL, 4'd3)),
			32'd7, 32'd7, 8'd0, 4'h3);
		send_fields(dp_word(1'b0, OP_TST, 1'b1, 4'd1, PC_REG, imm_shift(5'd0, SH_LSL, 4'd3)),
			32'd0, 32'd0, 8'd0, 4'h9);
		send_fields(dp_word(1'b0, OP_EOR, 1'b1, 4'd1, 4'd2,
			reg_shift(4'd4, SH_ASR, 4'd3) | 12'h080), 32'h1234_5678, 32'hF000_0000, 8'd4, 4'h0);
		send_fields(32'd0, 32'd0, 32'd0, 8'd0, 4'h0);
		send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				results_board.note_instruction(req_if.data);
			end
			if (rsp_if.valid && rsp_if.ready) begin
				results_board.check_result(rsp_if.data);
			end
		end
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// result side: random stalls, plus long hold-offs on request
	initial begin
		int stall;
		rsp_if.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		rsp_if.ready <= 1'b1;
		forever begin
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (hold_off_request) begin
				hold_off_request = 0;
				stall = LONG_HOLD_CYCLES;
			end else begin
				stall = burst_mode ? 0 : idle_gap();
			end
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				rsp_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		int i;
		results_board = new();
		quiet_cycles = 0;
		burst_mode = 0;
		hold_off_request = 0;
		req_if.valid <= 1'b0;
		req_if.data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		settle();
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0) begin
				burst_mode = ($urandom_range(0, 3) == 0);
			end
			if (i == 100 || i == 700) begin
				hold_off_request = 1;
			end
			if (i > 0 && i % 300 == 0) begin
				settle();
			end
			send_item(random_instruction());
		end
		settle();
		repeat (10) @(posedge clk);
		if (results_board.failures == 0 && results_board.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[arm_data_processing_alu.f]
rtl/adp_pkg.sv
rtl/adp_req_if.sv
rtl/adp_rsp_if.sv
rtl/adp_shifter.sv
rtl/adp_alu.sv
rtl/arm_data_processing_alu.sv
verif/arm_data_processing_alu_test.sv
